/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DBPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dbpm: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define DBPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dbpm: next-cycle check failed");

`endif

/* hw/rtl/dbpm_pkg.sv */
// Types, constants and the dB threshold table for the peak-hold meter.
package dbpm_pkg;

    localparam int DB_MAX_DEF      = 80;
    localparam int SAMPLE_BITS_DEF = 14;

    localparam int SMP_W     = 14;
    localparam int LVL_W     = 7;
    localparam int CNT_W     = 8;
    localparam int WGT_W     = 8;
    localparam int THR_W     = 20;
    localparam int NUM_W     = WGT_W + LVL_W;
    localparam int TABLE_LEN = 120;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [CNT_W-1:0] HOLD_RST   = 8'd5;
    localparam logic [WGT_W-1:0] WEIGHT_RST = 8'd6;

    typedef enum logic [0:0] {
        REG_HOLD   = 1'b0,
        REG_WEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_DIV,
        ST_DONE
    } t_state;

    // Smallest integer x with 20*log10(x) >= d, for d = 1..TABLE_LEN.
    localparam int unsigned DB_THRESH [TABLE_LEN] = '{
        2, 2, 2, 2, 2, 2, 3, 3, 3, 4,
        4, 4, 5, 6, 6, 7, 8, 8, 9, 10,
        12, 13, 15, 16, 18, 20, 23, 26, 29, 32,
        36, 40, 45, 51, 57, 64, 71, 80, 90, 100,
        113, 126, 142, 159, 178, 200, 224, 252, 282, 317,
        355, 399, 447, 502, 563, 631, 708, 795, 892, 1000,
        1123, 1259, 1413, 1585, 1779, 1996, 2239, 2512, 2819, 3163,
        3549, 3982, 4467, 5012, 5624, 6310, 7080, 7944, 8913, 10000,
        11221, 12590, 14126, 15849, 17783, 19953, 22388, 25119, 28184, 31623,
        35482, 39811, 44669, 50119, 56235, 63096, 70795, 79433, 89126, 100000,
        112202, 125893, 141254, 158490, 177828, 199527, 223873, 251189, 281839, 316228,
        354814, 398108, 446684, 501188, 562342, 630958, 707946, 794329, 891251, 1000000
    };

    function automatic logic [THR_W-1:0] db_thresh(input logic [LVL_W-1:0] d);
        logic [LVL_W-1:0] idx;
        idx = d - LVL_W'(1);
        if (d == '0) begin
            return '0;
        end else if (int'(d) > TABLE_LEN) begin
            return '1;
        end else begin
            return THR_W'(DB_THRESH[idx]);
        end
    endfunction

endpackage

/* hw/rtl/dbpm_level_search.sv */
// Bit-serial search of the dB threshold table, one level bit per cycle.
`include "assert_macros.svh"

module dbpm_level_search #(
    parameter int MAX_DB      = dbpm_pkg::DB_MAX_DEF,
    parameter int SAMPLE_BITS = dbpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dbpm_pkg::SMP_W-1:0] i_sample,
    output logic                       o_done,
    output logic [dbpm_pkg::LVL_W-1:0] o_level
);
    import dbpm_pkg::*;

    localparam int BIT_W = $clog2(LVL_W);
    localparam int KEEP  = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam logic [SMP_W-1:0] SMP_MASK = SMP_W'((64'(1) << KEEP) - 64'(1));

    logic             r_busy;
    logic             r_done;
    logic [BIT_W-1:0] r_bit;
    logic [LVL_W-1:0] r_level;
    logic [SMP_W-1:0] r_sample;
    logic [LVL_W-1:0] cand;
    logic             take;

    assign cand = r_level | (LVL_W'(1) << r_bit);
    assign take = (cand <= LVL_W'(MAX_DB)) && (THR_W'(r_sample) >= db_thresh(cand));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= r_busy && (r_bit == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= BIT_W'(LVL_W - 1);
            end else if (r_busy && (r_bit == '0)) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_bit <= r_bit - BIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sample <= i_sample & SMP_MASK;
            r_level  <= '0;
        end else if (r_busy && take) begin
            r_level <= cand;
        end
    end

    assign o_done  = r_done;
    assign o_level = r_level;

    `DBPM_ASSERT_IMPL(a_level_max, i_clk, i_rst_n, r_done, r_level <= LVL_W'(MAX_DB))

endmodule

/* hw/rtl/dbpm_decay_div.sv */
// Bit-serial restoring divider for the peak decay average.
`include "assert_macros.svh"

module dbpm_decay_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dbpm_pkg::NUM_W-1:0] i_num,
    input  logic [dbpm_pkg::WGT_W-1:0] i_den,
    output logic                       o_done,
    output logic [dbpm_pkg::LVL_W-1:0] o_quot
);
    import dbpm_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_num;
    logic [WGT_W-1:0]  r_rem;
    logic [WGT_W-1:0]  r_den;
    logic [WGT_W:0]    trial;
    logic              ge;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W - 1);
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? WGT_W'(trial - {1'b0, r_den}) : trial[WGT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[LVL_W-1:0];

    `DBPM_ASSERT_IMPL(a_quot_fits, i_clk, i_rst_n, r_done, r_num[NUM_W-1:LVL_W] == '0)

endmodule

/* hw/rtl/db_peak_hold_meter_core.sv */
// Peak-hold dB level meter top level: control, registers and output stage.
//
//  channel   | dir | beat fields
//  s_axis    | in  | tdata[13:0] signal_strength
//  m_axis    | out | tdata[6:0] level_db, tdata[13:7] peak_db
//  apb       | in  | reg 0 peak_hold_count @0x0, reg 1 average_weight @0x4
//
// A beat passes from accept through the bit-serial threshold search, one step per level
// bit, then the decide and done control states when the peak is raised or held.
// A decaying peak adds the 15-step serial divider between the decide and done states.
// A new beat is accepted once the previous one has reached the output register.
// Synchronous active-low reset: peak at MAX_DB, hold count zero, registers 5 and 6.
// A stalled output holds its beat; the next result waits until it is taken.
`include "assert_macros.svh"

module db_peak_hold_meter_core #(
    parameter int MAX_DB      = dbpm_pkg::DB_MAX_DEF,
    parameter int SAMPLE_BITS = dbpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dbpm_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [13:0] signal_strength
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dbpm_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [6:0] level_db, [13:7] peak_db
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dbpm_pkg::ADDR_W-1:0]    paddr,
    input  logic [dbpm_pkg::DATA_W-1:0]    pwdata,
    output logic [dbpm_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import dbpm_pkg::*;

    localparam int PEAK_LSB = LVL_W;
    localparam int PEAK_MSB = 2 * LVL_W - 1;

    t_state                 r_state;
    t_state                 n_state;
    logic [LVL_W-1:0]       r_peak;
    logic [LVL_W-1:0]       n_peak;
    logic [CNT_W-1:0]       r_hold;
    logic [CNT_W-1:0]       n_hold;
    logic [CNT_W-1:0]       r_hold_cnt;
    logic [WGT_W-1:0]       r_weight;
    logic                   r_m_tvalid;
    logic [M_TDATA_W-1:0]   r_m_tdata;

    logic                   s_accept;
    logic                   cfg_wr;
    t_reg_idx               cfg_idx;
    logic                   srch_done;
    logic [LVL_W-1:0]       srch_level;
    logic                   div_start;
    logic                   div_done;
    logic [LVL_W-1:0]       div_quot;
    logic [NUM_W-1:0]       div_num;
    logic                   out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign cfg_idx       = t_reg_idx'(paddr[2]);

    dbpm_level_search #(
        .MAX_DB      (MAX_DB),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_accept),
        .i_sample (s_axis_tdata[SMP_W-1:0]),
        .o_done   (srch_done),
        .o_level  (srch_level)
    );

    assign div_num = NUM_W'(r_weight - WGT_W'(1)) * NUM_W'(r_peak) + NUM_W'(srch_level);

    dbpm_decay_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_weight),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_peak  <= LVL_W'(MAX_DB);
            r_hold  <= '0;
        end else begin
            r_state <= n_state;
            r_peak  <= n_peak;
            r_hold  <= n_hold;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_peak    = r_peak;
        n_hold    = r_hold;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (srch_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (srch_level > r_peak) begin
                    n_peak  = srch_level;
                    n_hold  = r_hold_cnt;
                    n_state = ST_DONE;
                end else if (r_hold != '0) begin
                    n_hold  = r_hold - CNT_W'(1);
                    n_state = ST_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_peak  = div_quot;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= M_TDATA_W'({r_peak, srch_level});
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_cnt <= HOLD_RST;
            r_weight   <= WEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_HOLD:   r_hold_cnt <= pwdata[CNT_W-1:0];
                REG_WEIGHT: r_weight   <= (pwdata[WGT_W-1:0] == '0) ? WGT_W'(1)
                                                                     : pwdata[WGT_W-1:0];
                default:    r_hold_cnt <= r_hold_cnt;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_HOLD:   prdata = DATA_W'(r_hold_cnt);
            REG_WEIGHT: prdata = DATA_W'(r_weight);
            default:    prdata = '0;
        endcase
    end

    `DBPM_ASSERT_IMPL(a_peak_max, i_clk, i_rst_n, 1'b1, r_peak <= LVL_W'(MAX_DB))
    `DBPM_ASSERT_IMPL(a_peak_ge_level, i_clk, i_rst_n, r_m_tvalid,
                      r_m_tdata[PEAK_MSB:PEAK_LSB] >= r_m_tdata[LVL_W-1:0])
    `DBPM_ASSERT_IMPL(a_div_in_state, i_clk, i_rst_n, div_done, r_state == ST_DIV)
    `DBPM_ASSERT_NEXT(a_accept_search, i_clk, i_rst_n, s_accept, r_state == ST_SEARCH)

endmodule

/* sim/db_meter_reading_checker.sv */
// Checker for the dB peak-hold meter: predicts each level/peak reading and compares it.
module db_meter_reading_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [dbpm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,   // [13:0] signal_strength
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [dbpm_pkg::M_TDATA_W-1:0] i_m_axis_tdata,   // [6:0] level_db, [13:7] peak_db
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [dbpm_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [dbpm_pkg::DATA_W-1:0]    i_pwdata,
    output int                             o_fail_count,
    output int                             o_readings_due,
    output int                             o_readings_seen
);
    import dbpm_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_HOLD   = ADDR_W'(4 * int'(REG_HOLD));
    localparam logic [ADDR_W-1:0] ADDR_WEIGHT = ADDR_W'(4 * int'(REG_WEIGHT));

    typedef struct packed {
        logic [LVL_W-1:0] level_db;
        logic [LVL_W-1:0] peak_db;
    } t_reading;

    t_reading         expected_readings [$];
    logic [CNT_W-1:0] hold_setting;
    logic [WGT_W-1:0] weight_setting;
    logic [LVL_W-1:0] peak_now;
    logic [CNT_W-1:0] hold_left;
    int               fail_tally;
    int               seen_tally;

    function automatic logic [LVL_W-1:0] strength_to_db(input logic [SMP_W-1:0] x);
        logic [LVL_W-1:0] lvl;
        lvl = '0;
        for (int d = 1; d <= DB_MAX_DEF; d++) begin
            if (int'(x) >= int'(DB_THRESH[d-1])) begin
                lvl = LVL_W'(d);
            end
        end
        return lvl;
    endfunction

    // Advance the meter state by one sample and return its reading.
    function automatic t_reading meter_reading(input logic [SMP_W-1:0] x);
        t_reading r;
        int       w;
        r.level_db = strength_to_db(x);
        w = int'(weight_setting);
        if (r.level_db > peak_now) begin
            peak_now  = r.level_db;
            hold_left = hold_setting;
        end else if (hold_left == '0) begin
            peak_now = LVL_W'(((w - 1) * int'(peak_now) + int'(r.level_db)) / w);
        end else begin
            hold_left = hold_left - 1'b1;
        end
        r.peak_db = peak_now;
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_reading want;
        logic [LVL_W-1:0] got_level;
        logic [LVL_W-1:0] got_peak;
        if (!i_rst_n) begin
            hold_setting   = HOLD_RST;
            weight_setting = WEIGHT_RST;
            peak_now       = LVL_W'(DB_MAX_DEF);
            hold_left      = '0;
            expected_readings.delete();
            fail_tally = 0;
            seen_tally = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    ADDR_HOLD: begin
                        hold_setting = i_pwdata[CNT_W-1:0];
                    end
                    ADDR_WEIGHT: begin
                        weight_setting = (i_pwdata[WGT_W-1:0] == '0) ? WGT_W'(1)
                                                                     : i_pwdata[WGT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_readings.push_back(meter_reading(i_s_axis_tdata[SMP_W-1:0]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_level = i_m_axis_tdata[LVL_W-1:0];
                got_peak  = i_m_axis_tdata[2*LVL_W-1:LVL_W];
                seen_tally++;
                if (expected_readings.size() == 0) begin
                    $error("reading with no sample pending: level_db %0d, peak_db %0d",
                           got_level, got_peak);
                    fail_tally++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got_level !== want.level_db) begin
                        $error("level_db mismatch: expected %0d, actual %0d",
                               want.level_db, got_level);
                        fail_tally++;
                    end
                    if (got_peak !== want.peak_db) begin
                        $error("peak_db mismatch: expected %0d, actual %0d",
                               want.peak_db, got_peak);
                        fail_tally++;
                    end
                end
            end
        end
        o_fail_count    <= fail_tally;
        o_readings_due  <= expected_readings.size();
        o_readings_seen <= seen_tally;
    end

endmodule

/* sim/tb_db_peak_hold_meter_core.sv */
// Testbench top for the dB peak-hold meter: clock, reset, stimulus, register writes, verdict.
module tb_db_peak_hold_meter_core;
    import dbpm_pkg::*;

    localparam int                IDLE_LIMIT        = 3000;
    localparam int                LONG_STALL_CYCLES = 300;
    localparam int                PHASES            = 10;
    localparam int                PHASE_SAMPLES     = 153;
    localparam logic [ADDR_W-1:0] ADDR_HOLD         = ADDR_W'(4 * int'(REG_HOLD));
    localparam logic [ADDR_W-1:0] ADDR_WEIGHT       = ADDR_W'(4 * int'(REG_WEIGHT));

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [13:0] signal_strength
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [6:0] level_db, [13:7] peak_db
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_W-1:0]    paddr         = '0;
    logic [DATA_W-1:0]    pwdata        = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int fail_count;
    int readings_due;
    int readings_seen;
    int samples_sent    = 0;
    int settings_used   = 1;
    int burst_left      = 1;
    int idle_cycles     = 0;
    int long_stall_asks = 0;

    int unsigned opening_samples [19] = '{
        0, 1, 2, 3, 9, 10, 99, 100, 8912, 8913, 10000, 16383,
        0, 0, 0, 0, 0, 0, 16383
    };
    int unsigned hold_plan   [PHASES] = '{255, 0, 1, 256, 0, 255, 256, 3, 256, 5};
    int unsigned weight_plan [PHASES] = '{255, 1, 2, 256, 0, 1, 256, 255, 256, 6};

    db_peak_hold_meter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    db_meter_reading_checker reading_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_readings_due  (readings_due),
        .o_readings_seen (readings_seen)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stall the output on a changing pattern; hold off for a long stretch on request.
    initial begin
        int mode;
        int span;
        int stalls_done;
        stalls_done = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                if (long_stall_asks > stalls_done) begin
                    m_axis_tready <= 1'b0;
                    repeat (LONG_STALL_CYCLES) @(posedge i_clk);
                    stalls_done++;
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_sample(input logic [SMP_W-1:0] value);
        int gap;
        int r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(value);
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            r = $urandom_range(0, 19);
            if (r < 6) begin
                gap = 0;
            end else if (r < 14) begin
                gap = $urandom_range(1, 4);
            end else if (r < 18) begin
                gap = $urandom_range(5, 20);
            end else begin
                gap = $urandom_range(21, 60);
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (readings_due != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [WGT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (idx == REG_HOLD) ? ADDR_HOLD : ADDR_WEIGHT;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SMP_W-1:0] pick_strength();
        int kind;
        int k;
        int d;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            return SMP_W'($urandom_range(0, 16383));
        end else if (kind < 55) begin
            return SMP_W'($urandom_range(0, 40));
        end else if (kind < 75) begin
            k = $urandom_range(1, SMP_W);
            return SMP_W'($urandom_range(0, (1 << k) - 1));
        end else if (kind < 92) begin
            d = $urandom_range(1, DB_MAX_DEF);
            return SMP_W'(DB_THRESH[d-1] - $urandom_range(0, 1));
        end else begin
            return SMP_W'($urandom_range(10000, 16383));
        end
    endfunction

    initial begin
        logic [CNT_W-1:0] hold_val;
        logic [WGT_W-1:0] weight_val;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_samples[i]) begin
            send_sample(SMP_W'(opening_samples[i]));
        end
        // Shorten the hold while a countdown is still running.
        wait_drained();
        write_reg(REG_HOLD, 8'd2);
        repeat (4) send_sample('0);
        wait_drained();
        write_reg(REG_WEIGHT, 8'd0);
        write_reg(REG_HOLD, 8'd0);
        settings_used++;
        send_sample(SMP_W'(16383));
        send_sample(SMP_W'(100));
        send_sample('0);
        send_sample(SMP_W'(1000));

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            hold_val   = (hold_plan[p] > 255) ? CNT_W'($urandom_range(0, 255))
                                              : CNT_W'(hold_plan[p]);
            weight_val = (weight_plan[p] > 255) ? WGT_W'($urandom_range(0, 255))
                                                : WGT_W'(weight_plan[p]);
            write_reg(REG_HOLD, hold_val);
            write_reg(REG_WEIGHT, weight_val);
            settings_used++;
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                if (p == 2 && n == 50) begin
                    long_stall_asks++;
                end
                if (p == 5 && n == 75) begin
                    wait_drained();
                end
                send_sample(pick_strength());
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d samples and %0d readings over %0d register settings,",
                 samples_sent, readings_seen, settings_used);
        $display("with bursty input, random output stalls and one long output hold-off.");
        if (fail_count == 0 && readings_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
